// ----- design/hacm_pkg.sv -----
`default_nettype none

package hacm_pkg;

   localparam int CHANNEL_COUNT   = 16;
   localparam int CHAN_SEL_W      = $clog2(CHANNEL_COUNT);
   localparam int CHANNEL_INDEX_W = 4;
   localparam int CH_NUM_W        = 5;
   localparam int VALUE_W         = 12;
   localparam int ANGLE_W         = 13;
   localparam int TILT_W          = 12;
   localparam int WIDE_W          = 16;
   localparam int DIFF_W          = ANGLE_W + 1;
   localparam int GAIN_W          = 16;
   localparam int PROD_W          = DIFF_W + GAIN_W + 1;
   localparam int FRAC_W          = 12;
   localparam int SCALED_W        = PROD_W - FRAC_W;
   localparam int SUM_W           = SCALED_W + 1;
   localparam int CFG_W           = 59;
   localparam int CSR_INDEX_W     = 2;
   localparam int AXIS_COUNT      = 3;
   localparam int PIPE_DEPTH      = 5;

   // angle slots, as carried in the sample
   localparam int ANG_ROLL = 0;
   localparam int ANG_TILT = 1;
   localparam int ANG_PAN  = 2;

   localparam int HALF_TURN = 2880;
   localparam int FULL_TURN = 5760;

   localparam logic signed [WIDE_W-1:0] WRAP_LO2 = WIDE_W'(-(HALF_TURN + FULL_TURN));
   localparam logic signed [WIDE_W-1:0] WRAP_LO1 = WIDE_W'(-HALF_TURN);
   localparam logic signed [WIDE_W-1:0] WRAP_HI1 = WIDE_W'(HALF_TURN);
   localparam logic signed [WIDE_W-1:0] WRAP_HI2 = WIDE_W'(HALF_TURN + FULL_TURN);
   localparam logic signed [WIDE_W-1:0] TURN1    = WIDE_W'(FULL_TURN);
   localparam logic signed [WIDE_W-1:0] TURN2    = WIDE_W'(2 * FULL_TURN);

   typedef logic signed [ANGLE_W-1:0] hacm_angle_type;
   typedef logic [VALUE_W-1:0]        hacm_value_type;

   localparam hacm_value_type IDLE_VALUE = VALUE_W'(1500);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TILT = 2'd0,
      CSR_ROLL = 2'd1,
      CSR_PAN  = 2'd2
   } hacm_csr_type;

   // register order: tilt, roll, pan
   localparam int LANE_ANGLE [AXIS_COUNT] = '{ANG_TILT, ANG_ROLL, ANG_PAN};

   typedef struct packed {
      logic [CH_NUM_W-1:0] channel;
      logic                enable;
      logic                reverse;
      hacm_value_type      max_value;
      hacm_value_type      min_value;
      hacm_value_type      center;
      logic [GAIN_W-1:0]   gain;
   } hacm_axis_cfg_type;

   localparam hacm_axis_cfg_type TILT_CFG_RESET = '{
      channel: 5'd1, enable: 1'b1, reverse: 1'b0, max_value: 12'd2000,
      min_value: 12'd1000, center: 12'd1500, gain: 16'h0500};
   localparam hacm_axis_cfg_type ROLL_CFG_RESET = '{
      channel: 5'd2, enable: 1'b1, reverse: 1'b0, max_value: 12'd2000,
      min_value: 12'd1000, center: 12'd1500, gain: 16'h0500};
   localparam hacm_axis_cfg_type PAN_CFG_RESET = '{
      channel: 5'd3, enable: 1'b1, reverse: 1'b0, max_value: 12'd2000,
      min_value: 12'd1000, center: 12'd1500, gain: 16'h0500};

   typedef struct packed {
      logic load_diff;
      logic load_prod;
      logic load_scaled;
      logic load_value;
   } hacm_pipe_type;

   // fold into -180..180 degrees; input within two turns either way
   function automatic hacm_angle_type wrap_turn(input logic signed [WIDE_W-1:0] d);
      logic signed [WIDE_W-1:0] m;
      priority if (d < WRAP_LO2) begin
         m = d + TURN2;
      end else if (d < WRAP_LO1) begin
         m = d + TURN1;
      end else if (d >= WRAP_HI2) begin
         m = d - TURN2;
      end else if (d >= WRAP_HI1) begin
         m = d - TURN1;
      end else begin
         m = d;
      end
      return m[ANGLE_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- design/hacm_req_if.sv -----
`default_nettype none

interface hacm_req_if;
   import hacm_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [ANGLE_W-1:0]  roll_angle;
   logic signed [TILT_W-1:0]   tilt_angle;
   logic signed [ANGLE_W-1:0]  pan_angle;
   logic                       recenter_press;
   logic                       hold_toggle;

   modport source (
      output valid, roll_angle, tilt_angle, pan_angle, recenter_press, hold_toggle,
      input  ready
   );

   modport sink (
      input  valid, roll_angle, tilt_angle, pan_angle, recenter_press, hold_toggle,
      output ready
   );

endinterface

`default_nettype wire

// ----- design/hacm_rsp_if.sv -----
`default_nettype none

interface hacm_rsp_if;
   import hacm_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [CHANNEL_INDEX_W-1:0] channel_index;
   logic [VALUE_W-1:0]         channel_value;
   logic                       hold_active;
   logic                       last_channel;

   modport source (
      output valid, channel_index, channel_value, hold_active, last_channel,
      input  ready
   );

   modport sink (
      input  valid, channel_index, channel_value, hold_active, last_channel,
      output ready
   );

endinterface

`default_nettype wire

// ----- design/hacm_state.sv -----
`default_nettype none

module hacm_state (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  hacm_pkg::hacm_angle_type sample_angle [hacm_pkg::AXIS_COUNT],
   input  logic                    recenter_press,
   input  logic                    hold_toggle,
   output hacm_pkg::hacm_angle_type used_angle [hacm_pkg::AXIS_COUNT],
   output hacm_pkg::hacm_angle_type zero_offset [hacm_pkg::AXIS_COUNT],
   output logic                    hold_flag
);
   import hacm_pkg::*;

   logic                     hold_ff;
   logic                     hold_in;
   hacm_angle_type           held_ff   [AXIS_COUNT];
   hacm_angle_type           held_in   [AXIS_COUNT];
   hacm_angle_type           offset_ff [AXIS_COUNT];
   hacm_angle_type           offset_in [AXIS_COUNT];
   hacm_angle_type           used_ff   [AXIS_COUNT];
   hacm_angle_type           used_in   [AXIS_COUNT];
   logic signed [WIDE_W-1:0] rebase    [AXIS_COUNT];

   always_comb begin
      hold_in = hold_ff;
      for (int i = 0; i < AXIS_COUNT; i++) begin
         held_in[i]   = held_ff[i];
         offset_in[i] = offset_ff[i];
         rebase[i]    = WIDE_W'(sample_angle[i])
                        - (WIDE_W'(held_ff[i]) - WIDE_W'(offset_ff[i]));
      end
      if (accept) begin
         if (recenter_press) begin
            hold_in = 1'b0;
            for (int i = 0; i < AXIS_COUNT; i++) begin
               offset_in[i] = sample_angle[i];
            end
         end else if (hold_toggle) begin
            if (!hold_ff) begin
               hold_in = 1'b1;
               for (int i = 0; i < AXIS_COUNT; i++) begin
                  held_in[i] = sample_angle[i];
               end
            end else begin
               // release: shift offsets so output resumes from the held pose
               hold_in = 1'b0;
               for (int i = 0; i < AXIS_COUNT; i++) begin
                  offset_in[i] = (i == ANG_PAN) ? wrap_turn(rebase[i])
                                                : rebase[i][ANGLE_W-1:0];
               end
            end
         end
      end
      for (int i = 0; i < AXIS_COUNT; i++) begin
         used_in[i] = hold_in ? held_in[i] : sample_angle[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= 1'b0;
         for (int i = 0; i < AXIS_COUNT; i++) begin
            held_ff[i]   <= '0;
            offset_ff[i] <= '0;
         end
      end else begin
         hold_ff <= hold_in;
         for (int i = 0; i < AXIS_COUNT; i++) begin
            held_ff[i]   <= held_in[i];
            offset_ff[i] <= offset_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < AXIS_COUNT; i++) begin
            used_ff[i] <= used_in[i];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < AXIS_COUNT; i++) begin
         used_angle[i]  = used_ff[i];
         zero_offset[i] = offset_ff[i];
      end
   end

   assign hold_flag = hold_ff;

endmodule

`default_nettype wire

// ----- design/hacm_lane.sv -----
`default_nettype none

module hacm_lane (
   input  logic                        clock,
   input  hacm_pkg::hacm_pipe_type     pipe,
   input  hacm_pkg::hacm_axis_cfg_type cfg,
   input  logic                        pan_axis,
   input  hacm_pkg::hacm_angle_type    used_angle,
   input  hacm_pkg::hacm_angle_type    zero_offset,
   output hacm_pkg::hacm_value_type    axis_value
);
   import hacm_pkg::*;

   logic signed [DIFF_W-1:0]   raw_diff;
   logic signed [WIDE_W-1:0]   wide_diff;
   hacm_angle_type             wrapped;
   logic signed [DIFF_W-1:0]   diff_ff;
   logic signed [DIFF_W-1:0]   diff_in;
   logic signed [GAIN_W:0]     gain_s;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [PROD_W-1:0]   prod_in;
   logic signed [PROD_W-1:0]   magnitude;
   logic [SCALED_W-1:0]        trunc_mag;
   logic                       negate;
   logic signed [SCALED_W-1:0] scaled_ff;
   logic signed [SCALED_W-1:0] scaled_in;
   logic signed [SUM_W-1:0]    sum;
   logic signed [SUM_W-1:0]    hi_s;
   logic signed [SUM_W-1:0]    lo_s;
   logic signed [SUM_W-1:0]    upper;
   logic signed [SUM_W-1:0]    clamped;
   hacm_value_type             value_ff;
   hacm_value_type             value_in;

   // angle difference, pan folded to half a turn
   always_comb begin
      raw_diff  = DIFF_W'(used_angle) - DIFF_W'(zero_offset);
      wide_diff = WIDE_W'(raw_diff);
      wrapped   = wrap_turn(wide_diff);
      diff_in   = pan_axis ? {{(DIFF_W-ANGLE_W){wrapped[ANGLE_W-1]}}, wrapped} : raw_diff;
   end

   // unsigned Q4.12 gain
   always_comb begin
      gain_s  = $signed({1'b0, cfg.gain});
      prod_in = PROD_W'(diff_ff) * PROD_W'(gain_s);
   end

   // drop fraction toward zero, then apply reversal
   always_comb begin
      magnitude = prod_ff[PROD_W-1] ? -prod_ff : prod_ff;
      trunc_mag = magnitude[PROD_W-1:FRAC_W];
      negate    = prod_ff[PROD_W-1] ^ cfg.reverse;
      scaled_in = negate ? -$signed(trunc_mag) : $signed(trunc_mag);
   end

   // centre and clamp, min applied last; centre alone when the axis is disabled
   always_comb begin
      sum      = SUM_W'(scaled_ff) + SUM_W'($signed({1'b0, cfg.center}));
      hi_s     = $signed({{(SUM_W-VALUE_W){1'b0}}, cfg.max_value});
      lo_s     = $signed({{(SUM_W-VALUE_W){1'b0}}, cfg.min_value});
      upper    = (sum > hi_s) ? hi_s : sum;
      clamped  = (upper < lo_s) ? lo_s : upper;
      value_in = cfg.enable ? clamped[VALUE_W-1:0] : cfg.center;
   end

   always_ff @(posedge clock) begin
      if (pipe.load_diff) begin
         diff_ff <= diff_in;
      end
      if (pipe.load_prod) begin
         prod_ff <= prod_in;
      end
      if (pipe.load_scaled) begin
         scaled_ff <= scaled_in;
      end
      if (pipe.load_value) begin
         value_ff <= value_in;
      end
   end

   assign axis_value = value_ff;

endmodule

`default_nettype wire

// ----- design/hacm_serializer.sv -----
`default_nettype none

module hacm_serializer (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     frame_load,
   input  hacm_pkg::hacm_value_type axis_value   [hacm_pkg::AXIS_COUNT],
   input  logic [hacm_pkg::CH_NUM_W-1:0] axis_channel [hacm_pkg::AXIS_COUNT],
   input  logic                     frame_hold,
   output logic                     frame_free,
   hacm_rsp_if.source               rsp_if
);
   import hacm_pkg::*;

   hacm_value_type             frame_ff [CHANNEL_COUNT];
   hacm_value_type             frame_in [CHANNEL_COUNT];
   logic                       frame_hold_ff;
   logic                       busy_ff;
   logic                       busy_in;
   logic [CHAN_SEL_W-1:0]      sel_ff;
   logic [CHAN_SEL_W-1:0]      sel_in;
   logic                       out_load;
   logic                       emit;
   logic                       last_sel;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic [CHANNEL_INDEX_W-1:0] rsp_index_ff;
   hacm_value_type             rsp_value_ff;
   logic                       rsp_hold_ff;
   logic                       rsp_last_ff;

   // merge: later axes overwrite earlier ones
   always_comb begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
         frame_in[i] = IDLE_VALUE;
         for (int a = 0; a < AXIS_COUNT; a++) begin
            if (axis_channel[a] == CH_NUM_W'(i + 1)) begin
               frame_in[i] = axis_value[a];
            end
         end
      end
   end

   always_comb begin
      out_load     = !rsp_valid_ff || rsp_if.ready;
      emit         = busy_ff && out_load;
      last_sel     = (sel_ff == CHAN_SEL_W'(CHANNEL_COUNT - 1));
      frame_free   = !busy_ff || (emit && last_sel);
      rsp_valid_in = out_load ? busy_ff : rsp_valid_ff;
      busy_in      = busy_ff;
      sel_in       = sel_ff;
      if (emit) begin
         sel_in = CHAN_SEL_W'(sel_ff + 1'b1);
         if (last_sel) begin
            busy_in = 1'b0;
         end
      end
      if (frame_load) begin
         busy_in = 1'b1;
         sel_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         sel_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_load) begin
         for (int i = 0; i < CHANNEL_COUNT; i++) begin
            frame_ff[i] <= frame_in[i];
         end
         frame_hold_ff <= frame_hold;
      end
      if (emit) begin
         rsp_index_ff <= CHANNEL_INDEX_W'(sel_ff);
         rsp_value_ff <= frame_ff[sel_ff];
         rsp_hold_ff  <= frame_hold_ff;
         rsp_last_ff  <= last_sel;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.channel_index = rsp_index_ff;
   assign rsp_if.channel_value = rsp_value_ff;
   assign rsp_if.hold_active   = rsp_hold_ff;
   assign rsp_if.last_channel  = rsp_last_ff;

endmodule

`default_nettype wire

// ----- design/head_angle_to_channel_mapper_unit.sv -----
// Head angle to channel mapper. Each orientation beat (roll, tilt, pan in
// 1/16 degree, plus recenter and hold-toggle events) yields CHANNEL_COUNT
// result beats (16 by default), channel 0 first, last_channel on the last.
// The three axes run in parallel lanes through a five-stage pipeline
// (sample capture and hold state, difference and pan wrap, gain multiply,
// truncate and reverse, centre and clamp), which feeds the frame register
// of the result serializer; a stalled result port can hold any stage.
// The result port moves one channel per cycle while the receiver is ready;
// later samples are taken while a frame drains and wait in the pipeline.
// Settings registers may only be written while no sample is in flight.
`default_nettype none

module head_angle_to_channel_mapper_unit (
   input  logic                               clock,
   input  logic                               reset,
   hacm_req_if.sink                           req_if,
   hacm_rsp_if.source                         rsp_if,
   input  logic                               csr_write_enable,
   input  logic [hacm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [hacm_pkg::CFG_W-1:0]         csr_write_data
);
   import hacm_pkg::*;

   hacm_axis_cfg_type      cfg_ff [AXIS_COUNT];
   hacm_angle_type         sample_angle [AXIS_COUNT];
   hacm_angle_type         used_angle   [AXIS_COUNT];
   hacm_angle_type         zero_offset  [AXIS_COUNT];
   hacm_value_type         axis_value   [AXIS_COUNT];
   logic [CH_NUM_W-1:0]    axis_channel [AXIS_COUNT];
   logic                   state_hold;
   logic                   accept;
   logic                   frame_free;
   logic                   frame_load;
   logic [PIPE_DEPTH-1:0]  valid_ff;
   logic [PIPE_DEPTH-1:0]  valid_in;
   logic [PIPE_DEPTH-1:0]  rdy;
   logic [PIPE_DEPTH-1:1]  stage_load;
   logic                   hold_pipe_ff [PIPE_DEPTH-1];
   hacm_pipe_type          pipe;

   // settings
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[CSR_TILT] <= TILT_CFG_RESET;
         cfg_ff[CSR_ROLL] <= ROLL_CFG_RESET;
         cfg_ff[CSR_PAN]  <= PAN_CFG_RESET;
      end else if (csr_write_enable) begin
         unique case (hacm_csr_type'(csr_index))
            CSR_TILT: begin
               cfg_ff[CSR_TILT] <= csr_write_data;
            end
            CSR_ROLL: begin
               cfg_ff[CSR_ROLL] <= csr_write_data;
            end
            CSR_PAN: begin
               cfg_ff[CSR_PAN] <= csr_write_data;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      sample_angle[ANG_ROLL] = req_if.roll_angle;
      sample_angle[ANG_TILT] = {{(ANGLE_W-TILT_W){req_if.tilt_angle[TILT_W-1]}},
                                req_if.tilt_angle};
      sample_angle[ANG_PAN]  = req_if.pan_angle;
      for (int a = 0; a < AXIS_COUNT; a++) begin
         axis_channel[a] = cfg_ff[a].channel;
      end
   end

   // pipeline flow control
   always_comb begin
      rdy[PIPE_DEPTH-1] = !valid_ff[PIPE_DEPTH-1] || frame_free;
      for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
         rdy[k] = !valid_ff[k] || rdy[k+1];
      end
      accept      = req_if.valid && rdy[0];
      valid_in[0] = rdy[0] ? req_if.valid : valid_ff[0];
      for (int k = 1; k < PIPE_DEPTH; k++) begin
         stage_load[k] = valid_ff[k-1] && rdy[k];
         valid_in[k]   = rdy[k] ? valid_ff[k-1] : valid_ff[k];
      end
      frame_load = valid_ff[PIPE_DEPTH-1] && frame_free;
   end

   assign req_if.ready     = rdy[0];
   assign pipe.load_diff   = stage_load[1];
   assign pipe.load_prod   = stage_load[2];
   assign pipe.load_scaled = stage_load[3];
   assign pipe.load_value  = stage_load[4];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_load[1]) begin
         hold_pipe_ff[0] <= state_hold;
      end
      for (int k = 2; k < PIPE_DEPTH; k++) begin
         if (stage_load[k]) begin
            hold_pipe_ff[k-1] <= hold_pipe_ff[k-2];
         end
      end
   end

   hacm_state u_state (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .sample_angle   (sample_angle),
      .recenter_press (req_if.recenter_press),
      .hold_toggle    (req_if.hold_toggle),
      .used_angle     (used_angle),
      .zero_offset    (zero_offset),
      .hold_flag      (state_hold)
   );

   for (genvar a = 0; a < AXIS_COUNT; a++) begin : g_lane
      hacm_lane u_lane (
         .clock       (clock),
         .pipe        (pipe),
         .cfg         (cfg_ff[a]),
         .pan_axis    (a == int'(CSR_PAN)),
         .used_angle  (used_angle[LANE_ANGLE[a]]),
         .zero_offset (zero_offset[LANE_ANGLE[a]]),
         .axis_value  (axis_value[a])
      );
   end

   hacm_serializer u_serializer (
      .clock        (clock),
      .reset        (reset),
      .frame_load   (frame_load),
      .axis_value   (axis_value),
      .axis_channel (axis_channel),
      .frame_hold   (hold_pipe_ff[PIPE_DEPTH-2]),
      .frame_free   (frame_free),
      .rsp_if       (rsp_if)
   );

endmodule

`default_nettype wire

// ----- design/hacm_checker.sv -----
`default_nettype none

module hacm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  rsp_channel_index,
   input logic [11:0] rsp_channel_value,
   input logic        rsp_hold_active,
   input logic        rsp_last_channel
);

   // stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_channel_index)
         && $stable(rsp_channel_value) && $stable(rsp_hold_active)
         && $stable(rsp_last_channel))
      else $error("result beat changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a frame drains without gaps, channels in order, one hold state
   a_frame_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_channel |=> rsp_valid
         && rsp_channel_index == 4'($past(rsp_channel_index) + 4'd1)
         && rsp_hold_active == $past(rsp_hold_active))
      else $error("frame beat out of order");

   a_frame_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_channel |=> !rsp_valid || rsp_channel_index == 4'd0)
      else $error("new frame does not start at channel zero");

endmodule

bind head_angle_to_channel_mapper_unit hacm_checker u_hacm_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_channel_index (rsp_if.channel_index),
   .rsp_channel_value (rsp_if.channel_value),
   .rsp_hold_active   (rsp_if.hold_active),
   .rsp_last_channel  (rsp_if.last_channel)
);

`default_nettype wire
